FILE: rtl/core/hxcrc_pkg.sv
// ----------------------------------------------------------------------------
// hxcrc_pkg: shared constants and functions for the hex-text CRC-32 block
// Holds the reflected CRC-32 polynomial, the counter width and the helpers
// that turn a nibble into an ASCII hex character and fold one byte into a CRC.
// ----------------------------------------------------------------------------
package hxcrc_pkg;

   localparam int unsigned CRC_W      = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned NIBBLES    = WORD_W / 4;

   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

   localparam logic [7:0] ASCII_ZERO     = 8'h30;
   localparam logic [7:0] ASCII_A_MINUS_10 = 8'h37;

   // Upper-case ASCII hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'h0, nibble};
      if (nibble < 4'd10) begin
         hex_char = ASCII_ZERO + wide;
      end else begin
         hex_char = ASCII_A_MINUS_10 + wide;
      end
   endfunction

   // Fold one byte into a reflected CRC, least significant bit first.
   function automatic logic [CRC_W-1:0] crc_feed_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [7:0]       data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-8){1'b0}}, data};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY_REFL : '0);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/hxcrc_update.sv
// ----------------------------------------------------------------------------
// hxcrc_update: CRC-32 update over the hex text of one 32-bit word
// Renders the word as eight hex characters, most significant nibble first,
// and folds them into the running CRC. Purely combinational.
// ----------------------------------------------------------------------------
module hxcrc_update (
   input  logic [hxcrc_pkg::CRC_W-1:0]  crc_in,
   input  logic [hxcrc_pkg::WORD_W-1:0] word,
   output logic [hxcrc_pkg::CRC_W-1:0]  crc_out
);
   import hxcrc_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_in;
      for (int i = NIBBLES - 1; i >= 0; i--) begin
         c = crc_feed_byte(c, hex_char(word[4*i +: 4]));
      end
      crc_out = c;
   end

endmodule

FILE: rtl/core/hex_text_crc32_checksum.sv
// ----------------------------------------------------------------------------
// hex_text_crc32_checksum: CRC-32 over the hex text of calibration words
// Accumulates CRC-32/ISO-HDLC over the upper-case hex rendering of a block
// of BLOCK_WORDS 32-bit words and returns one checksum per block.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req_word) carries one word per
//   request, in block order. Response channel (rsp_valid, rsp_stall,
//   rsp_checksum) carries one checksum after the last word of each block.
//   Each request passes an input register, then the CRC update into the
//   running value and, for the last word, into the response register.
//   Throughput is one request per cycle while req_stall stays low; the
//   limit is the running-CRC feedback, which the combinational update
//   network closes.
//   While a checksum waits under rsp_stall, words that do not end a block
//   keep flowing; the block's last word waits in the input register and
//   req_stall rises until the response register is free.
//   Synchronous reset drops any partial block, clears both valid flags and
//   returns the running CRC to all ones and the word count to zero.
// ----------------------------------------------------------------------------
module hex_text_crc32_checksum #(
   parameter int unsigned BLOCK_WORDS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hxcrc_pkg::WORD_W-1:0] req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hxcrc_pkg::CRC_W-1:0]  rsp_checksum
);
   import hxcrc_pkg::*;

   localparam logic [COUNT_W:0] LAST_COUNT = (COUNT_W + 1)'(BLOCK_WORDS);

   logic                req_valid_ff, req_valid_in;
   logic [WORD_W-1:0]   req_word_ff;
   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]    rsp_checksum_ff;

   logic [CRC_W-1:0]    crc_next;
   logic [COUNT_W:0]    count_inc;
   logic                last_word;
   logic                out_free;
   logic                work_fire;
   logic                load_req;

   hxcrc_update u_update (
      .crc_in  (crc_ff),
      .word    (req_word_ff),
      .crc_out (crc_next)
   );

   always_comb begin
      count_inc = {1'b0, count_ff} + (COUNT_W + 1)'(1);
      last_word = (count_inc >= LAST_COUNT);
      out_free  = !rsp_valid_ff || !rsp_stall;
      work_fire = req_valid_ff && (!last_word || out_free);
      req_stall = req_valid_ff && !work_fire;
      load_req  = req_valid && !req_stall;

      req_valid_in = load_req || (req_valid_ff && !work_fire);

      crc_in   = crc_ff;
      count_in = count_ff;
      if (work_fire) begin
         if (last_word) begin
            crc_in   = CRC_ALL_ONES;
            count_in = '0;
         end else begin
            crc_in   = crc_next;
            count_in = count_inc[COUNT_W-1:0];
         end
      end

      // Hold a waiting checksum until taken, load a new one on block end.
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (work_fire && last_word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         crc_ff       <= CRC_ALL_ONES;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         req_word_ff <= req_word;
      end
      if (work_fire && last_word) begin
         rsp_checksum_ff <= crc_next ^ CRC_ALL_ONES;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: checksum test for hex_text_crc32_checksum
// Streams 32-bit words into the block and checks every returned checksum
// against a local CRC-32 predictor that works over the hex text of each word.
// Both channels idle in random bursts, and the output side also holds off for
// a long stretch so that the block backs up. The sender also pauses once
// until every outstanding checksum has come back.
// ----------------------------------------------------------------------------
module tb_top;
   import hxcrc_pkg::*;

   localparam int unsigned BLOCK_LEN      = 10;
   localparam int unsigned RANDOM_WORDS   = 1333;
   localparam int unsigned QUIET_TAIL     = 150;
   localparam int unsigned HOLD_START     = 400;
   localparam int unsigned HOLD_CYCLES    = 120;
   localparam int unsigned DRAIN_AT       = 800;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned CYCLE_LIMIT    = 400000;

   // Reflected CRC-32 over the upper-case hex spelling of each word.
   class crc_scoreboard;
      int unsigned      block_len;
      logic [CRC_W-1:0] crc_acc;
      int unsigned      words_in_block;
      logic [CRC_W-1:0] checksum_q[$];
      int unsigned      failures;
      int unsigned      words_taken;
      int unsigned      checksums_checked;

      function new(int unsigned len);
         block_len         = len;
         crc_acc           = CRC_ALL_ONES;
         words_in_block    = 0;
         failures          = 0;
         words_taken       = 0;
         checksums_checked = 0;
      endfunction

      function logic [7:0] hex_digit_ascii(logic [3:0] nib);
         localparam logic [7:0] DIGIT_BASE  = 8'h30;
         localparam logic [7:0] LETTER_BASE = 8'h41;
         if (nib < 4'd10) begin
            return DIGIT_BASE + {4'h0, nib};
         end else begin
            return LETTER_BASE + {4'h0, nib} - 8'd10;
         end
      endfunction

      // Bit-serial form: feedback is the low CRC bit against the data bit.
      function logic [CRC_W-1:0] absorb_char(logic [CRC_W-1:0] acc, logic [7:0] ch);
         logic [CRC_W-1:0] v;
         v = acc;
         for (int k = 0; k < 8; k++) begin
            if (v[0] ^ ch[k]) begin
               v = (v >> 1) ^ CRC_POLY_REFL;
            end else begin
               v = v >> 1;
            end
         end
         return v;
      endfunction

      function void note_word(logic [WORD_W-1:0] w);
         for (int n = WORD_W / 4 - 1; n >= 0; n--) begin
            crc_acc = absorb_char(crc_acc, hex_digit_ascii(w[4*n +: 4]));
         end
         words_taken++;
         words_in_block++;
         if (words_in_block >= block_len) begin
            checksum_q.push_back(crc_acc ^ CRC_ALL_ONES);
            crc_acc        = CRC_ALL_ONES;
            words_in_block = 0;
         end
      endfunction

      function void check_checksum(logic [CRC_W-1:0] got);
         logic [CRC_W-1:0] want;
         if (checksum_q.size() == 0) begin
            $display("%0t: checksum with none expected, actual %h", $time, got);
            failures++;
            return;
         end
         want = checksum_q.pop_front();
         checksums_checked++;
         if (got !== want) begin
            $display("%0t: checksum expected %h actual %h", $time, want, got);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return checksum_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [WORD_W-1:0] req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CRC_W-1:0]  rsp_checksum;

   crc_scoreboard board;
   bit            idle_enable  = 1'b1;
   bit            hold_request = 1'b0;
   int unsigned   hold_left    = 0;
   int unsigned   burst_left   = 0;
   int unsigned   cycle_count  = 0;

   hex_text_crc32_checksum #(.BLOCK_WORDS(BLOCK_LEN)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_checksum (rsp_checksum)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_checksum(rsp_checksum);
      end
   end

   // Output side: long hold when asked, else random stall bursts.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!idle_enable) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Enter and leave at a falling edge; valid stays high on return.
   task automatic send_word(input logic [WORD_W-1:0] w);
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_word(w);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      w = '0;
      case ($urandom_range(0, 7))
         4: for (int n = 0; n < WORD_W / 4; n++) w[4*n +: 4] = 4'($urandom_range(0, 9));
         5: for (int n = 0; n < WORD_W / 4; n++) w[4*n +: 4] = 4'($urandom_range(10, 15));
         6: begin
            case ($urandom_range(0, 3))
               0: w = '0;
               1: w = '1;
               2: w = 32'h1 << $urandom_range(0, 31);
               default: w = ~(32'h1 << $urandom_range(0, 31));
            endcase
         end
         // nibbles on the digit/letter boundary
         7: for (int n = 0; n < WORD_W / 4; n++) w[4*n +: 4] = 4'($urandom_range(8, 11));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   logic [WORD_W-1:0] directed_words[] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0009, 32'h0000_000A, 32'h0000_000F,
      32'h9999_9999, 32'hAAAA_AAAA, 32'hFFFF_FFF0, 32'h0123_4567, 32'h89AB_CDEF,
      32'hFEDC_BA98, 32'h7654_3210, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
      32'h9A9A_9A9A, 32'hA9A9_A9A9, 32'hDEAD_BEEF, 32'h5555_5555, 32'hF0F0_0F0F
   };

   initial begin
      bit segment_idle;
      board        = new(BLOCK_LEN);
      segment_idle = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_words[i]) begin
         send_word(directed_words[i]);
         sender_gap();
      end

      for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 120 == 0) begin
            segment_idle = ($urandom_range(0, 3) != 0);
         end
         idle_enable = segment_idle && !(i >= HOLD_START && i < HOLD_START + 60)
                       && (i < RANDOM_WORDS - QUIET_TAIL);
         if (i == HOLD_START) begin
            hold_request = 1'b1;
         end
         if (i == DRAIN_AT) begin
            // hold the sender until every checksum is back
            req_valid <= 1'b0;
            do begin
               @(negedge clock);
            end while (board.pending() != 0);
         end
         send_word(pick_word());
         sender_gap();
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d words in blocks of %0d, %0d checksums compared, %0d failures.",
               board.words_taken, BLOCK_LEN, board.checksums_checked, board.failures);
      $display("Covered digit/letter extremes, long output hold and a full drain pause.");
      if (board.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
